/* src/rcd_pkg.sv */
package rcd_pkg;

  localparam int unsigned CHUNK_W = 31;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 31'd128;
  localparam int unsigned QDEPTH_DEF = 4;

  localparam logic [7:0] TYPE_SET_CHUNK = 8'd1;
  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;
  localparam logic [23:0] TS_ESCAPE = 24'hFFFFFF;

  typedef enum logic [2:0] {
    PH_BASIC0,
    PH_BASIC1,
    PH_BASIC2,
    PH_MSGHDR,
    PH_EXTTS,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [16:0] chunk_stream_id;
    logic [7:0]  message_type;
    logic [31:0] message_stream_id;
    logic [23:0] message_length;
    logic [31:0] header_time;
    logic        first_of_message;
    logic        last_of_message;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
    logic [3:0] r;
    unique case (fmt)
      2'd0: r = 4'd11;
      2'd1: r = 4'd7;
      2'd2: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_av(input logic [7:0] t);
    return (t == TYPE_AUDIO) || (t == TYPE_VIDEO);
  endfunction

endpackage

/* src/rtmp_chunk_deframer.sv */
// A payload beat is written into the queue and then into the output register before it leaves.
// Throughput: one input byte per cycle; the parser accepts while the queue has room.
// The output register and a 4-entry queue let input and output stall separately.
// Reset (rst, synchronous, active high) clears parse state, queue and time base;
// chunk size returns to 128.
module rtmp_chunk_deframer
  import rcd_pkg::*;
#(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // payload_byte, payload_valid, chunk_stream_id, message_type, message_stream_id,
  // message_length, message_time, first_of_message, last_of_message
  output logic [127:0]       m_axis_tdata,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_data
);

  logic   q_full, q_push, q_valid, q_pop;
  entry_t q_in, q_out;

  rcd_parser u_parser (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_ready(s_axis_tready),
    .q_full, .q_push, .q_entry(q_in),
    .cfg_we, .cfg_data
  );

  rcd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  rcd_emitter u_emit (
    .clk, .rst, .q_valid, .q_data(q_out), .q_pop,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule

/* src/rcd_parser.sv */
module rcd_parser
  import rcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output entry_t             q_entry,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_data
);

  phase_t             phase, phase_next;
  logic [3:0]         hcnt;
  logic [1:0]         fmt;
  logic [16:0]        csid;
  logic [31:0]        hts;
  logic [23:0]        len;
  logic [7:0]         mtype;
  logic [31:0]        mstream;
  logic [23:0]        asm_cnt;
  logic [CHUNK_W-1:0] left;
  logic [CHUNK_W-1:0] csize;
  logic [31:0]        cw;

  logic               go;
  logic [23:0]        remaining;
  logic [16:0]        csid_n;
  logic [31:0]        hts_n;
  logic [23:0]        len_n;
  logic [7:0]         mtype_n;
  logic [31:0]        mstream_n;
  logic [3:0]         hcnt_inc;
  logic               hdr_done;
  logic               msg_done;
  logic               start;
  logic [1:0]         fmt_n;
  logic [23:0]        asm_inc;
  logic               pay_last;
  logic [31:0]        cw_n;
  logic               complete;
  logic               chunk_set;
  logic [CHUNK_W-1:0] chunk_value;

  assign in_ready = !q_full;
  assign go = in_valid && in_ready;
  assign hcnt_inc = hcnt + 4'd1;
  assign asm_inc = asm_cnt + 24'd1;
  assign pay_last = asm_inc >= len;
  assign remaining = (len_n > asm_cnt) ? len_n - asm_cnt : 24'd0;

  always_comb begin
    fmt_n = fmt;
    csid_n = csid;
    hts_n = hts;
    len_n = len;
    mtype_n = mtype;
    mstream_n = mstream;
    hdr_done = 1'b0;
    msg_done = 1'b0;
    phase_next = phase;
    unique case (phase)
      PH_BASIC0: begin
        fmt_n = in_byte[7:6];
        csid_n = {11'd0, in_byte[5:0]};
        if (in_byte[5:1] == 5'd0) phase_next = PH_BASIC1;
        else hdr_done = 1'b1;
      end
      PH_BASIC1: begin
        csid_n = 17'd64 + {9'd0, in_byte};
        if (csid == 17'd1) phase_next = PH_BASIC2;
        else hdr_done = 1'b1;
      end
      PH_BASIC2: begin
        csid_n = csid + {1'b0, in_byte, 8'd0};
        hdr_done = 1'b1;
      end
      PH_MSGHDR: begin
        if (hcnt == 4'd0) hts_n = {24'd0, in_byte};
        else if (hcnt <= 4'd2) hts_n = {8'd0, hts[15:0], in_byte};
        else if (hcnt == 4'd3) len_n = {16'd0, in_byte};
        else if (hcnt <= 4'd5) len_n = {len[15:0], in_byte};
        else if (hcnt == 4'd6) mtype_n = in_byte;
        else if (hcnt == 4'd7) mstream_n = {24'd0, in_byte};
        else if (hcnt == 4'd8) mstream_n[15:8] = in_byte;
        else if (hcnt == 4'd9) mstream_n[23:16] = in_byte;
        else mstream_n[31:24] = in_byte;
        if (hcnt_inc >= hdr_len(fmt)) msg_done = 1'b1;
      end
      PH_EXTTS: begin
        hts_n = (hcnt == 4'd0) ? {24'd0, in_byte} : {hts[23:0], in_byte};
        if (hcnt == 4'd3) phase_next = PH_BASIC0;
      end
      PH_PAYLOAD: begin
        if (pay_last || left <= CHUNK_W'(1)) phase_next = PH_BASIC0;
      end
      default: phase_next = PH_BASIC0;
    endcase
    if (hdr_done) begin
      if (hdr_len(fmt_n) == 4'd0) msg_done = 1'b1;
      else phase_next = PH_MSGHDR;
    end
    start = (phase == PH_EXTTS) && (hcnt == 4'd3);
    if (msg_done) begin
      if (hts_n == {8'd0, TS_ESCAPE}) phase_next = PH_EXTTS;
      else start = 1'b1;
    end
    if (start) phase_next = (remaining == 24'd0) ? PH_BASIC0 : PH_PAYLOAD;
  end

  // first four payload bytes, big-endian
  always_comb begin
    cw_n = cw;
    if (phase == PH_PAYLOAD) begin
      if (asm_cnt == 24'd0) cw_n = 32'd0;
      if (asm_cnt < 24'd4) begin
        case (asm_cnt[1:0])
          2'd0: cw_n[31:24] = in_byte;
          2'd1: cw_n[23:16] = in_byte;
          2'd2: cw_n[15:8] = in_byte;
          default: cw_n[7:0] = in_byte;
        endcase
      end
    end else if (start && remaining == 24'd0 && asm_cnt == 24'd0) begin
      cw_n = 32'd0;
    end
  end

  assign complete = go && ((phase == PH_PAYLOAD && pay_last) ||
                           (start && remaining == 24'd0));
  assign chunk_set = complete && mtype_n == TYPE_SET_CHUNK;
  assign chunk_value = (cw_n[30:0] == '0) ? CHUNK_W'(1) : cw_n[30:0];

  always_comb begin
    q_entry.payload_byte = 8'd0;
    q_entry.payload_valid = 1'b0;
    q_entry.chunk_stream_id = csid_n;
    q_entry.message_type = mtype_n;
    q_entry.message_stream_id = mstream_n;
    q_entry.message_length = len_n;
    q_entry.header_time = hts_n;
    q_entry.first_of_message = (asm_cnt == 24'd0);
    q_entry.last_of_message = 1'b1;
    q_push = 1'b0;
    if (go && phase == PH_PAYLOAD) begin
      q_push = 1'b1;
      q_entry.payload_byte = in_byte;
      q_entry.payload_valid = 1'b1;
      q_entry.last_of_message = pay_last;
    end else if (go && start && remaining == 24'd0) begin
      q_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BASIC0;
      hcnt <= 4'd0;
      fmt <= 2'd0;
      csid <= 17'd0;
      hts <= 32'd0;
      len <= 24'd0;
      mtype <= 8'd0;
      mstream <= 32'd0;
      asm_cnt <= 24'd0;
      left <= '0;
      csize <= CHUNK_RESET;
      cw <= 32'd0;
    end else begin
      if (cfg_we) csize <= (cfg_data == '0) ? CHUNK_W'(1) : cfg_data;
      else if (chunk_set) csize <= chunk_value;
      if (go) begin
        phase <= phase_next;
        fmt <= fmt_n;
        csid <= csid_n;
        hts <= hts_n;
        len <= len_n;
        mtype <= mtype_n;
        mstream <= mstream_n;
        cw <= cw_n;
        if (phase == PH_MSGHDR || phase == PH_EXTTS) hcnt <= hcnt_inc;
        if (phase_next != phase || hdr_done) hcnt <= 4'd0;
        if (start) begin
          if (remaining == 24'd0) asm_cnt <= 24'd0;
          else left <= ({7'd0, remaining} < csize) ? {7'd0, remaining} : csize;
        end
        if (phase == PH_PAYLOAD) begin
          if (pay_last) begin
            asm_cnt <= 24'd0;
            left <= '0;
          end else begin
            asm_cnt <= asm_inc;
            if (left != '0) left <= left - CHUNK_W'(1);
          end
        end
      end
    end
  end

endmodule

/* src/rcd_queue.sv */
module rcd_queue
  import rcd_pkg::*;
#(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  output logic   pop_valid,
  input  logic   pop,
  output entry_t pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t        mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (pop) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* src/rcd_emitter.sv */
module rcd_emitter
  import rcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  entry_t       q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_data
);

  logic [31:0] base;
  logic        base_ok;
  logic [31:0] mtime;
  logic        take;
  logic [7:0]  ob;

  assign mtime = (is_av(q_data.message_type) && base_ok) ?
                 base + q_data.header_time : q_data.header_time;
  assign q_pop = q_valid && (!out_valid || out_ready);
  assign take = q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      base <= 32'd0;
      base_ok <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        if (q_data.last_of_message && is_av(q_data.message_type)) begin
          base <= mtime;
          base_ok <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ob = q_data.payload_byte;

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= {4'd0, q_data.last_of_message, q_data.first_of_message, mtime,
                   q_data.message_length, q_data.message_stream_id, q_data.message_type,
                   q_data.chunk_stream_id, q_data.payload_valid, ob};
    end
  end

endmodule

/* src/rcd_checker.sv */
module rcd_props (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[123])
    else $error("marker beat malformed");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");

endmodule

bind rtmp_chunk_deframer rcd_props u_chk (.*);

/* dv/rcd_checker.sv */
`timescale 1ns / 1ps

module rcd_checker
  import rcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [127:0]       m_axis_tdata,
  input  logic               cfg_we,
  input  logic [CHUNK_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  phase_t       ph;
  logic [3:0]   hcnt;
  logic [1:0]   fmt;
  logic [16:0]  csid;
  logic [31:0]  hts;
  logic [23:0]  mlen;
  logic [7:0]   mtype;
  logic [31:0]  mstream;
  logic [23:0]  nasm;
  logic [30:0]  left;
  logic [30:0]  csize;
  logic [31:0]  ctrl;
  logic [31:0]  tbase;
  logic         tbv;
  logic [127:0] beats_due[$];

  initial errors = 0;
  assign pending = beats_due.size();

  function automatic logic [3:0] hdr_bytes(input logic [1:0] f);
    case (f)
      2'd0: return 4'd11;
      2'd1: return 4'd7;
      2'd2: return 4'd3;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [31:0] msg_time();
    if ((mtype == TYPE_AUDIO || mtype == TYPE_VIDEO) && tbv) return tbase + hts;
    return hts;
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic v, input logic f, input logic l);
    beats_due.push_back({4'b0, l, f, msg_time(), mlen, mstream, mtype, csid, v, b});
  endtask

  task automatic finish_msg();
    if (mtype == TYPE_SET_CHUNK) begin
      csize = (ctrl[30:0] == 0) ? 31'd1 : ctrl[30:0];
    end else if (mtype == TYPE_AUDIO || mtype == TYPE_VIDEO) begin
      tbase = msg_time();
      tbv = 1'b1;
    end
  endtask

  task automatic open_payload();
    logic [23:0] remaining;
    remaining = (mlen > nasm) ? mlen - nasm : 24'd0;
    if (remaining == 0) begin
      if (nasm == 0) ctrl = 0;
      push_beat(8'd0, 1'b0, nasm == 0, 1'b1);
      finish_msg();
      nasm = 0;
      ph = PH_BASIC0;
    end else begin
      left = ({7'd0, remaining} < csize) ? {7'd0, remaining} : csize;
      ph = PH_PAYLOAD;
    end
  endtask

  task automatic close_msg_hdr();
    hcnt = 0;
    if (hts == 32'hFFFFFF) ph = PH_EXTTS;
    else open_payload();
  endtask

  task automatic close_basic_hdr();
    hcnt = 0;
    if (hdr_bytes(fmt) == 0) close_msg_hdr();
    else ph = PH_MSGHDR;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic first, last;
    case (ph)
      PH_BASIC0: begin
        fmt = b[7:6];
        csid = {11'd0, b[5:0]};
        if (csid <= 1) ph = PH_BASIC1;
        else close_basic_hdr();
      end
      PH_BASIC1: begin
        if (csid == 1) begin
          csid = 17'd64 + b;
          ph = PH_BASIC2;
        end else begin
          csid = 17'd64 + b;
          close_basic_hdr();
        end
      end
      PH_BASIC2: begin
        csid = csid + {1'b0, b, 8'd0};
        close_basic_hdr();
      end
      PH_MSGHDR: begin
        if (hcnt == 0) hts = {24'd0, b};
        else if (hcnt <= 2) hts = {8'd0, hts[15:0], b};
        else if (hcnt == 3) mlen = {16'd0, b};
        else if (hcnt <= 5) mlen = {mlen[15:0], b};
        else if (hcnt == 6) mtype = b;
        else if (hcnt == 7) mstream = {24'd0, b};
        else mstream = mstream | ({24'd0, b} << (8 * (hcnt - 7)));
        hcnt = hcnt + 1;
        if (hcnt >= hdr_bytes(fmt)) close_msg_hdr();
      end
      PH_EXTTS: begin
        hts = (hcnt == 0) ? {24'd0, b} : {hts[23:0], b};
        hcnt = hcnt + 1;
        if (hcnt >= 4) begin
          hcnt = 0;
          open_payload();
        end
      end
      PH_PAYLOAD: begin
        first = (nasm == 0);
        if (first) ctrl = 0;
        if (nasm < 4) ctrl = ctrl | ({24'd0, b} << (8 * (3 - nasm)));
        nasm = nasm + 1;
        last = (nasm >= mlen);
        push_beat(b, 1'b1, first, last);
        if (left > 0) left = left - 1;
        if (last) begin
          finish_msg();
          nasm = 0;
          left = 0;
          ph = PH_BASIC0;
        end else if (left == 0) begin
          ph = PH_BASIC0;
        end
      end
      default: ph = PH_BASIC0;
    endcase
  endtask

  task automatic cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    logic [127:0] e;
    logic [127:0] a;
    if (rst) begin
      ph = PH_BASIC0;
      hcnt = 0; fmt = 0; csid = 0; hts = 0; mlen = 0; mtype = 0; mstream = 0;
      nasm = 0; left = 0; csize = CHUNK_RESET; ctrl = 0; tbase = 0; tbv = 0;
      beats_due.delete();
    end else begin
      if (cfg_we) csize = (cfg_data == 0) ? 31'd1 : cfg_data;
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        a = m_axis_tdata;
        if (beats_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat expected none actual %h", $realtime, a);
        end else begin
          e = beats_due.pop_front();
          cmp("payload_byte", e[7:0], a[7:0]);
          cmp("payload_valid", e[8], a[8]);
          cmp("chunk_stream_id", e[25:9], a[25:9]);
          cmp("message_type", e[33:26], a[33:26]);
          cmp("message_stream_id", e[65:34], a[65:34]);
          cmp("message_length", e[89:66], a[89:66]);
          cmp("message_time", e[121:90], a[121:90]);
          cmp("first_of_message", e[122], a[122]);
          cmp("last_of_message", e[123], a[123]);
          cmp("pad", e[127:124], a[127:124]);
        end
      end
    end
  end

endmodule

/* dv/tb_rtmp_chunk_deframer.sv */
`timescale 1ns / 1ps

module tb_rtmp_chunk_deframer;
  import rcd_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = 0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [127:0]       m_axis_tdata;
  logic               cfg_we = 0;
  logic [CHUNK_W-1:0] cfg_data = 0;
  int                 errors;
  int                 pending;
  int                 src_idle = 0;
  int                 snk_idle = 0;
  int                 quiet = 0;
  int                 cs = 128;
  logic [31:0]        hts_gen;
  logic [7:0]         stream_bytes[$];

  rtmp_chunk_deframer i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  rcd_checker i_chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic put(input logic [7:0] b);
    stream_bytes.push_back(b);
  endtask

  task automatic put_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) put(v[8*i +: 8]);
  endtask

  task automatic put_basic(input logic [1:0] f, input int id);
    if (id >= 2 && id < 64) begin
      put({f, id[5:0]});
    end else if (id < 320 && $urandom_range(1)) begin
      put({f, 6'd0});
      put(8'(id - 64));
    end else begin
      put({f, 6'd1});
      put(8'((id - 64) % 256));
      put(8'((id - 64) / 256));
    end
  endtask

  // one message as fmt 0 (or fmt 1) header plus fmt 3 continuation chunks
  task automatic gen_msg(input bit use_fmt1, input int id, input logic [7:0] mt,
                         input int len, input logic [23:0] ts, input logic [31:0] ext,
                         input logic [31:0] sid, input logic [31:0] cv);
    logic [31:0] v;
    logic [7:0]  b;
    put_basic(use_fmt1 ? 2'd1 : 2'd0, id);
    put_be({8'd0, ts}, 3);
    put_be(len, 3);
    put(mt);
    if (!use_fmt1) for (int i = 0; i < 4; i++) put(sid[8*i +: 8]);
    hts_gen = {8'd0, ts};
    if (ts == TS_ESCAPE) begin
      put_be(ext, 4);
      hts_gen = ext;
    end
    v = 0;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && i % cs == 0) begin
        put_basic(2'd3, id);
        if (hts_gen == 32'hFFFFFF) begin
          hts_gen = $urandom;
          put_be(hts_gen, 4);
        end
      end
      b = (mt == TYPE_SET_CHUNK && i < 4) ? cv[31 - 8*i -: 8] : 8'($urandom);
      if (i < 4) v = v | ({24'd0, b} << (24 - 8*i));
      put(b);
    end
    if (mt == TYPE_SET_CHUNK) cs = (v[30:0] == 0) ? 1 : int'(v[30:0]);
  endtask

  task automatic gen_random(input int nbytes);
    int target, id, len, sel;
    logic [7:0] mt;
    logic [23:0] ts;
    logic [31:0] cv;
    target = stream_bytes.size() + nbytes;
    while (stream_bytes.size() < target) begin
      sel = $urandom_range(9);
      case (sel)
        0: mt = TYPE_SET_CHUNK;
        1, 2: mt = TYPE_AUDIO;
        3, 4: mt = TYPE_VIDEO;
        default: mt = 8'($urandom);
      endcase
      sel = $urandom_range(2);
      id = (sel == 0) ? $urandom_range(2, 63) :
           (sel == 1) ? $urandom_range(64, 319) : $urandom_range(320, 65599);
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
      if (mt == TYPE_SET_CHUNK) len = ($urandom_range(4) == 0) ? $urandom_range(0, 6) : 4;
      ts = ($urandom_range(7) == 0) ? TS_ESCAPE : 24'($urandom);
      sel = $urandom_range(19);
      cv = (sel == 0) ? 32'd0 : (sel == 1) ? $urandom : $urandom_range(1, 40);
      if ($urandom_range(9) == 0) cv[31] = 1'b1;
      gen_msg($urandom_range(3) == 0, id, mt, len, ts, $urandom, $urandom, cv);
    end
  endtask

  task automatic drive_all();
    while (stream_bytes.size() > 0) begin
      if ($urandom_range(99) < src_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stream_bytes.pop_front();
        do @(posedge clk); while (!s_axis_tready);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_chunk(input logic [30:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cs = (v == 0) ? 1 : int'(v);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    write_chunk(31'd16);
    gen_msg(0, 3, 8'd20, 0, 24'd5, 0, 32'd1, 0);
    gen_msg(0, 2, TYPE_SET_CHUNK, 4, 24'd0, 0, 32'd0, 32'd0);
    gen_msg(0, 4, 8'd18, 3, 24'd7, 0, 32'd2, 0);
    gen_msg(0, 2, TYPE_SET_CHUNK, 4, 24'd0, 0, 32'd0, 32'h8000_0010);
    gen_msg(0, 65599, TYPE_AUDIO, 3, TS_ESCAPE, 32'h1234_5678, 32'hFFFF_FFFF, 0);
    gen_msg(1, 64, TYPE_VIDEO, 2, 24'h10, 0, 0, 0);
    gen_msg(0, 319, TYPE_AUDIO, 20, TS_ESCAPE, 32'h00FF_FFFF, 32'h0, 0);
    gen_msg(0, 63, TYPE_SET_CHUNK, 2, 24'd0, 0, 32'd0, 32'h0000_0100);
    gen_msg(0, 5, TYPE_SET_CHUNK, 4, 24'd0, 0, 32'd0, 32'd16);
    put(8'h05); put_be(32'd1, 3); put_be(32'd20, 3); put(8'd18); put_be(32'h0700_0000, 4);
    repeat (16) put(8'hFF);
    put(8'h45); put_be(32'd3, 3); put_be(32'd5, 3); put(8'd18);
    put(8'h06); put_be(32'd2, 3); put_be(32'd20, 3); put(8'd18); put_be(32'h0, 4);
    repeat (16) put(8'h00);
    put(8'h86); put_be(32'd9, 3);
    repeat (4) put(8'($urandom));
    gen_msg(0, 7, TYPE_AUDIO, 0, 24'hFFFFFE, 0, 32'd3, 0);
    drive_all();

    write_chunk(31'd5);
    src_idle = 6; snk_idle = 62;
    gen_random(140);
    drive_all();

    write_chunk(31'd1);
    src_idle = 62; snk_idle = 6;
    gen_random(140);
    drive_all();

    write_chunk(31'h7FFF_FFFF);
    src_idle = 0; snk_idle = 0;
    gen_random(90);
    repeat (24) put(8'($urandom));
    repeat (4) put(8'hC2);
    drive_all();

    drain();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/rcd_pkg.sv
src/rcd_parser.sv
src/rcd_queue.sv
src/rcd_emitter.sv
src/rtmp_chunk_deframer.sv
src/rcd_checker.sv
dv/rcd_checker.sv
dv/tb_rtmp_chunk_deframer.sv
